// ===== src/ssmv_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sparse symmetric matrix-vector core.
// Holds item types, command and register codes, sequencer states and Q16.16 helpers.
package ssmv_pkg;

	localparam int MAX_ORDER  = 1024;
	localparam int IDX_BITS   = $clog2(MAX_ORDER);
	localparam int LEN_BITS   = IDX_BITS + 1;
	localparam int VALUE_BITS = 32;
	localparam int PROD_BITS  = 2 * VALUE_BITS;
	localparam int FRAC_BITS  = 16;
	localparam int SHR_BITS   = PROD_BITS - FRAC_BITS;
	localparam int SUM_BITS   = SHR_BITS + 1;
	localparam int CFG_IDX_BITS = 3;

	localparam logic signed [VALUE_BITS-1:0] ONE = VALUE_BITS'(65536);

	typedef enum logic [1:0] {
		CMD_LOAD_X = 2'd0,
		CMD_LOAD_Y = 2'd1,
		CMD_ENTRY  = 2'd2,
		CMD_READ_Y = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ALPHA    = 3'd0,
		REG_BETA     = 3'd1,
		REG_UPPER    = 3'd2,
		REG_BY_ROWS  = 3'd3,
		REG_LENGTH   = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LDY_MUL,
		ST_LDY_WR,
		ST_TRM_RD,
		ST_TRM_M1,
		ST_TRM_M2,
		ST_TRM_WR,
		ST_RDY_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]                   cmd;
		logic [IDX_BITS-1:0]          row_index;
		logic [IDX_BITS-1:0]          col_index;
		logic signed [VALUE_BITS-1:0] data_value;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] y_value;
		logic                         status;
	} out_item_t;

	// Saturate a wide signed value to VALUE_BITS signed bits.
	function automatic logic signed [VALUE_BITS-1:0] sat_value(
		input logic signed [SUM_BITS-1:0] v);
		logic [SUM_BITS-VALUE_BITS:0] top;
		top = v[SUM_BITS-1:VALUE_BITS-1];
		if ((&top) || !(|top)) begin
			return v[VALUE_BITS-1:0];
		end
		return v[SUM_BITS-1] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
		                     : {1'b0, {(VALUE_BITS-1){1'b1}}};
	endfunction

	// Q16.16 product scaling: drop the fraction rounding toward minus infinity.
	function automatic logic signed [SUM_BITS-1:0] shr_frac(
		input logic signed [PROD_BITS-1:0] p);
		return {p[PROD_BITS-1], p[PROD_BITS-1:FRAC_BITS]};
	endfunction

endpackage

// ===== src/sparse_symmetric_matvec_core.sv =====
`timescale 1ns / 1ps
// Sparse symmetric y = beta*y + alpha*A*x core with x and y in single-port RAMs.
// Depends on ssmv_pkg for item types, codes and fixed-point helpers.
// Items are taken only in idle. Load x writes as it is taken, load y passes LDY_MUL, LDY_WR;
// an entry makes one TRM_RD/M1/M2/WR read-modify-write pass on the y RAM, two off the diagonal;
// read y waits in RDY_OUT for a free output register. Rejected entries return to idle at once.
// Reset idles control, clears the output register and sets config defaults; x and y RAMs stay undefined until loaded.
module sparse_symmetric_matvec_core import ssmv_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  in_item_t                in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output out_item_t               out_data,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [VALUE_BITS-1:0]   cfg_data
);

	// configuration
	logic signed [VALUE_BITS-1:0] alpha_q, beta_q;
	logic                         upper_q, by_rows_q;
	logic [LEN_BITS-1:0]          vlen_q;

	// item context
	state_t                       state_q, state_d;
	cmd_t                         cmd_q;
	logic [IDX_BITS-1:0]          i_q, j_q;
	logic signed [VALUE_BITS-1:0] d_q;
	logic                         ok_q, phase_q;

	// memories
	logic signed [VALUE_BITS-1:0] x_mem [MAX_ORDER];
	logic signed [VALUE_BITS-1:0] y_mem [MAX_ORDER];
	logic signed [VALUE_BITS-1:0] x_rdata_q, y_rdata_q;

	// arithmetic pipeline
	logic signed [PROD_BITS-1:0]  prod_s1, prod_s2;

	// output register
	logic                         out_valid_q;
	out_item_t                    out_q;

	// control from the output decoder
	logic                         in_xfer, out_free;
	logic                         x_we, x_re, y_we, y_re;
	logic [IDX_BITS-1:0]          x_addr, y_addr, src_idx, dst_idx;
	logic signed [VALUE_BITS-1:0] x_wdata, y_wdata;
	logic [IDX_BITS-1:0]          ei, ej;
	logic                         r_ok, e_ok, keep;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	// decode an arriving item
	assign ei   = by_rows_q ? in_data.col_index : in_data.row_index;
	assign ej   = by_rows_q ? in_data.row_index : in_data.col_index;
	assign r_ok = {1'b0, in_data.row_index} < vlen_q;
	assign e_ok = ({1'b0, ei} < vlen_q) && ({1'b0, ej} < vlen_q);
	assign keep = e_ok && (upper_q ? (ei <= ej) : (ei >= ej));

	assign src_idx = phase_q ? i_q : j_q;
	assign dst_idx = phase_q ? j_q : i_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q   <= ONE;
			beta_q    <= ONE;
			upper_q   <= 1'b0;
			by_rows_q <= 1'b0;
			vlen_q    <= LEN_BITS'(MAX_ORDER);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ALPHA:   alpha_q   <= cfg_data;
				REG_BETA:    beta_q    <= cfg_data;
				REG_UPPER:   upper_q   <= cfg_data[0];
				REG_BY_ROWS: by_rows_q <= cfg_data[0];
				REG_LENGTH:  vlen_q    <= cfg_data[LEN_BITS-1:0];
				default:     ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					unique case (cmd_t'(in_data.cmd))
						CMD_LOAD_X: state_d = ST_IDLE;
						CMD_LOAD_Y: state_d = r_ok ? ST_LDY_MUL : ST_IDLE;
						CMD_ENTRY:  state_d = keep ? ST_TRM_RD : ST_IDLE;
						CMD_READ_Y: state_d = ST_RDY_OUT;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_LDY_MUL: state_d = ST_LDY_WR;
			ST_LDY_WR:  state_d = ST_IDLE;
			ST_TRM_RD:  state_d = ST_TRM_M1;
			ST_TRM_M1:  state_d = ST_TRM_M2;
			ST_TRM_M2:  state_d = ST_TRM_WR;
			ST_TRM_WR:  state_d = (!phase_q && (i_q != j_q)) ? ST_TRM_RD : ST_IDLE;
			ST_RDY_OUT: state_d = out_free ? ST_IDLE : ST_RDY_OUT;
			default:    state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		x_we    = 1'b0;
		x_re    = 1'b0;
		y_we    = 1'b0;
		y_re    = 1'b0;
		x_addr  = src_idx;
		y_addr  = dst_idx;
		x_wdata = in_data.data_value;
		y_wdata = sat_value(SUM_BITS'(y_rdata_q) + shr_frac(prod_s2));
		unique case (state_q)
			ST_IDLE: begin
				x_addr = in_data.row_index;
				y_addr = in_data.row_index;
				if (in_xfer && (cmd_t'(in_data.cmd) == CMD_LOAD_X)) begin
					x_we = r_ok;
				end
				if (in_xfer && (cmd_t'(in_data.cmd) == CMD_READ_Y)) begin
					y_re = r_ok;
				end
			end
			ST_LDY_WR: begin
				y_addr  = i_q;
				y_wdata = sat_value(shr_frac(prod_s1));
				y_we    = 1'b1;
			end
			ST_TRM_RD: begin
				x_re = 1'b1;
				y_re = 1'b1;
			end
			ST_TRM_WR: y_we = 1'b1;
			default: ;
		endcase
	end

	// x and y RAMs, one port each, registered read
	always_ff @(posedge clk) begin
		if (x_we) begin
			x_mem[x_addr] <= x_wdata;
		end
		if (x_re) begin
			x_rdata_q <= x_mem[x_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (y_we) begin
			y_mem[y_addr] <= y_wdata;
		end
		if (y_re) begin
			y_rdata_q <= y_mem[y_addr];
		end
	end

	// multiply stages: a*x then alpha*term, or beta*d for y loads
	always_ff @(posedge clk) begin
		if (state_q == ST_LDY_MUL) begin
			prod_s1 <= beta_q * d_q;
		end else if (state_q == ST_TRM_M1) begin
			prod_s1 <= d_q * x_rdata_q;
		end
		if (state_q == ST_TRM_M2) begin
			prod_s2 <= alpha_q * sat_value(shr_frac(prod_s1));
		end
	end

	// hold the item context; advance to the mirrored pass only off the diagonal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= CMD_LOAD_X;
			i_q     <= '0;
			j_q     <= '0;
			d_q     <= '0;
			ok_q    <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				cmd_q   <= cmd_t'(in_data.cmd);
				i_q     <= (cmd_t'(in_data.cmd) == CMD_ENTRY) ? ei : in_data.row_index;
				j_q     <= ej;
				d_q     <= in_data.data_value;
				ok_q    <= r_ok;
				phase_q <= 1'b0;
			end else if ((state_q == ST_TRM_WR) && (i_q != j_q)) begin
				phase_q <= 1'b1;
			end
		end
	end

	// output register: load on a read, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if ((state_q == ST_RDY_OUT) && out_free) begin
			out_valid_q   <= 1'b1;
			out_q.y_value <= ok_q ? y_rdata_q : '0;
			out_q.status  <= !ok_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// the single y port never reads and writes in one cycle
	a_y_port: assert property (@(posedge clk) disable iff (!arst_n) !(y_we && y_re))
		else $error("y RAM read and write collide");

	// a result appears only out of the read state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RDY_OUT))
		else $error("result without a read");

	// an out-of-range read returns zero
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status) |-> (out_q.y_value == '0))
		else $error("nonzero value with error status");

	// the second term pass only follows an off-diagonal first pass
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(phase_q) |-> (cmd_q == CMD_ENTRY) && (i_q != j_q))
		else $error("second pass on a diagonal entry");

endmodule
